### rtl/wbss_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scan package
// Shared types, register codes and sizing constants for the scanner.
// ----------------------------------------------------------------------------
package wbss_pkg;

  // Default number of signature positions (one scan cell each).
  localparam int unsigned PatternMaxDefault = 16;

  // Signature bytes that have pattern and care registers behind them.
  localparam int unsigned SigRegBytes = 16;

  // Configuration port sizing.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned LenRegW  = 5;

  // Register indexes, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_CARE    = 3'd2,
    REG_LENGTH  = 3'd3,
    REG_BASE    = 3'd4
  } reg_idx_e;

  // Register file contents handed to the scan logic.
  typedef struct packed {
    logic [63:0]        pattern_lo;
    logic [63:0]        pattern_hi;
    logic [31:0]        care_mask;
    logic [LenRegW-1:0] pattern_length;
    logic [AddrW-1:0]   base_address;
  } cfg_t;

  // Per-cell control from the scan sequencer.
  typedef struct packed {
    logic update;  // take the shifted flag this cycle
    logic clear;   // end of range, drop the flag
    logic active;  // position lies inside the signature length
    logic tail;    // position is the last byte of the signature
  } cell_ctrl_t;

endpackage

### rtl/wbss_cfg.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scan register file
// APB-style register bank holding the signature, care mask, length and base.
// ----------------------------------------------------------------------------
module wbss_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbss_pkg::CfgAddrW-1:0] paddr,
  input  logic [wbss_pkg::CfgDataW-1:0] pwdata,
  output logic [wbss_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output wbss_pkg::cfg_t                cfg_o
);

  wbss_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        wbss_pkg::REG_PAT_LO: cfg_d.pattern_lo     = pwdata;
        wbss_pkg::REG_PAT_HI: cfg_d.pattern_hi     = pwdata;
        wbss_pkg::REG_CARE:   cfg_d.care_mask      = pwdata[31:0];
        wbss_pkg::REG_LENGTH: cfg_d.pattern_length = pwdata[wbss_pkg::LenRegW-1:0];
        wbss_pkg::REG_BASE:   cfg_d.base_address   = pwdata[wbss_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wbss_pkg::REG_PAT_LO: prdata = cfg_q.pattern_lo;
      wbss_pkg::REG_PAT_HI: prdata = cfg_q.pattern_hi;
      wbss_pkg::REG_CARE:   prdata = {32'd0, cfg_q.care_mask};
      wbss_pkg::REG_LENGTH: prdata = {{(wbss_pkg::CfgDataW-wbss_pkg::LenRegW){1'b0}},
                                      cfg_q.pattern_length};
      wbss_pkg::REG_BASE:   prdata = {32'd0, cfg_q.base_address};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/wbss_cell.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scan cell
// One signature position: nibble compare with wildcards and a partial-match
// flag that is handed to the next cell.
// ----------------------------------------------------------------------------
module wbss_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wbss_pkg::cell_ctrl_t   ctrl_i,
  input  logic [7:0]             data_i,
  input  logic [7:0]             pat_i,
  input  logic [1:0]             care_i,   // bit 1 high nibble, bit 0 low nibble
  input  logic                   prev_i,   // flag of the previous position
  output logic                   flag_o,
  output logic                   match_o
);

  logic       flag_q, flag_d;
  logic [7:0] diff;
  logic       hit;
  logic       next_flag;

  assign diff      = pat_i ^ data_i;
  assign hit       = (!care_i[1] || (diff[7:4] == 4'h0)) &&
                     (!care_i[0] || (diff[3:0] == 4'h0));
  assign next_flag = prev_i & hit & ctrl_i.active;

  // The whole signature is matched when the tail position gets its flag.
  assign match_o = next_flag & ctrl_i.tail;
  assign flag_o  = flag_q;

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.update) begin
      flag_d = next_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

endmodule

### rtl/wildcard_byte_signature_scan.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scan
// Streams memory bytes through a row of shift-and cells and reports the
// first occurrence of a nibble-wildcard signature as an address range.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction contents
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata[31:0] match_start, [63:32] match_end,
//                       tuser[0] found
//  APB       in         pattern low/high, care mask, length, base address
//
// For every byte, all cells compare it in parallel and each hands its
// partial-match flag to its neighbor at the same edge. A result is
// registered in the cycle after the byte that causes it. The single output
// register is refilled in the cycle it drains, so bytes stream at one per
// cycle as long as m_axis_tready is high; s_axis_tready drops only while a
// result waits and m_axis_tready is low. Reset clears the flags, the byte
// position, the done flag, the output valid flag and all configuration.
//
// The block reports at most one result per range: found with the matched
// range, not found with an empty range at the base address on the final
// byte, or not found at base+1 on the first byte when the length is zero.
// Later bytes of the range are consumed without a result; the final byte
// restarts the search for the next range.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan #(
  parameter int unsigned PATTERN_MAX = wbss_pkg::PatternMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input bytes.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // last_byte
  // Results.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // [31:0] match_start,
                                                        // [63:32] match_end
  output logic                          m_axis_tuser,   // [0] found
  // Configuration.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbss_pkg::CfgAddrW-1:0] paddr,
  input  logic [wbss_pkg::CfgDataW-1:0] pwdata,
  output logic [wbss_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned AW   = wbss_pkg::AddrW;

  wbss_pkg::cfg_t cfg;

  wbss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective length, clamped to the number of cells. An 8-bit working width
  // covers every cell count in range.
  logic [7:0]      len_raw;
  logic [7:0]      len_lim;
  logic [LenW-1:0] len_eff;

  assign len_raw = {3'd0, cfg.pattern_length};
  assign len_lim = (len_raw > 8'(PATTERN_MAX)) ? 8'(PATTERN_MAX) : len_raw;
  assign len_eff = len_lim[LenW-1:0];

  // Scan sequencing.
  logic          accept;
  logic          process;
  logic          zero_len;
  logic          update;
  logic          match;
  logic          res_valid;
  logic          done_q, done_d;
  logic [AW-1:0] pos_q, pos_d;

  logic [PATTERN_MAX-1:0] flags;
  logic [PATTERN_MAX-1:0] cell_match;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign process  = accept & ~done_q;
  assign zero_len = (len_lim == 8'd0);
  assign update   = process & ~zero_len;
  assign match    = update & (|cell_match);

  // Row of cells. Positions beyond the register file compare as wildcards.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wbss_pkg::cell_ctrl_t ctrl;
    logic [7:0]           pat;
    logic [1:0]           care;
    logic                 prev;

    assign ctrl.update = update;
    assign ctrl.clear  = accept & s_axis_tlast;
    assign ctrl.active = (8'(i) < len_lim);
    assign ctrl.tail   = (8'(i + 1) == len_lim);

    if (i < wbss_pkg::SigRegBytes) begin : g_reg
      if (i < 8) begin : g_lo
        assign pat = cfg.pattern_lo[8*i +: 8];
      end else begin : g_hi
        assign pat = cfg.pattern_hi[8*(i-8) +: 8];
      end
      assign care = cfg.care_mask[2*i +: 2];
    end else begin : g_wild
      assign pat  = 8'h00;
      assign care = 2'b00;
    end

    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = flags[i-1];
    end

    wbss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .data_i  (s_axis_tdata),
      .pat_i   (pat),
      .care_i  (care),
      .prev_i  (prev),
      .flag_o  (flags[i]),
      .match_o (cell_match[i])
    );
  end

  // Result fields. The match ends just after the current byte and starts one
  // signature length earlier, both modulo 2^32.
  logic [AW-1:0] end_addr;
  logic [AW-1:0] start_addr;
  logic [AW-1:0] base_plus1;
  logic          res_found;
  logic [AW-1:0] res_start;
  logic [AW-1:0] res_end;

  assign end_addr   = cfg.base_address + pos_q + AW'(1);
  assign start_addr = end_addr - AW'(len_eff);
  assign base_plus1 = cfg.base_address + AW'(1);

  assign res_valid = process & (zero_len | match | s_axis_tlast);

  always_comb begin
    if (zero_len) begin
      res_found = 1'b0;
      res_start = base_plus1;
      res_end   = base_plus1;
    end else if (match) begin
      res_found = 1'b1;
      res_start = start_addr;
      res_end   = end_addr;
    end else begin
      res_found = 1'b0;
      res_start = cfg.base_address;
      res_end   = cfg.base_address;
    end
  end

  // The final byte of a range always restarts the search.
  always_comb begin
    done_d = done_q;
    pos_d  = pos_q;
    if (accept && s_axis_tlast) begin
      done_d = 1'b0;
      pos_d  = '0;
    end else begin
      if (process && (zero_len || match)) begin
        done_d = 1'b1;
      end
      if (update) begin
        pos_d = pos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      done_q <= done_d;
      pos_q  <= pos_d;
    end
  end

  // Output register. It may be reloaded in the same cycle it drains.
  logic          out_valid_q, out_valid_d;
  logic          out_found_q;
  logic [AW-1:0] out_start_q;
  logic [AW-1:0] out_end_q;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_found_q <= res_found;
      out_start_q <= res_start;
      out_end_q   <= res_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_end_q, out_start_q};
  assign m_axis_tuser  = out_found_q;

endmodule
